// ----- rtl/mxt_pkg.sv -----
// Shared constants and types of the maximum-xor trie unit.
package mxt_pkg;

  // Default sizing of the trie.
  localparam int DEF_NODES     = 32768;
  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_MAX_ITEMS = 1024;

  // Width of the word and result fields on the ports.
  localparam int FIELD_BITS = 32;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Control of the bit-serial word and result shifter.
  typedef struct packed {
    logic load;
    logic rewind;
    logic step;
    logic best_bit;
  } shift_ctl_t;

endpackage

// ----- rtl/mxt_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module mxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- rtl/mxt_shifter.sv -----
// Bit-serial word shifter and result accumulator of the trie walk.
module mxt_shifter #(
  parameter int WORD_BITS = mxt_pkg::DEF_WORD_BITS
) (
  input  logic                  clk,
  input  mxt_pkg::shift_ctl_t   ctl,
  input  logic [WORD_BITS-1:0]  word_in,
  output logic                  cur_bit,
  output logic [WORD_BITS-1:0]  best
);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] shift_r;
  logic [WORD_BITS-1:0] best_r;

  // The word leaves most significant bit first; the result enters the same way.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word_r  <= word_in;
      shift_r <= word_in;
      best_r  <= '0;
    end else if (ctl.rewind) begin
      shift_r <= word_r;
    end else if (ctl.step) begin
      shift_r <= {shift_r[WORD_BITS-2:0], 1'b0};
      best_r  <= {best_r[WORD_BITS-2:0], ctl.best_bit};
    end
  end

  assign cur_bit = shift_r[WORD_BITS-1];
  assign best    = best_r;

endmodule

// ----- rtl/multiset_max_xor_trie_unit.sv -----
// Multiset of words with a maximum-xor query, kept as a binary trie in a node RAM.
// Each transaction takes one operation. The trie is walked one bit level per clock,
// most significant bit first, and every level costs one registered read of the node
// RAM. A query makes one pass down the trie and an insert one write pass; a delete,
// or an insert when fewer than WORD_BITS nodes remain free, makes a check pass first
// because the path is checked before it is changed. Errors found at acceptance
// (empty set, full set) go straight to the result without a walk. One transaction
// is in work at a time; a finished result waits in the output register while the
// next one is accepted.
// The node RAM needs no clearing after reset: nodes are initialized as allocated.
module multiset_max_xor_trie_unit #(
  parameter int NODES     = mxt_pkg::DEF_NODES,
  parameter int WORD_BITS = mxt_pkg::DEF_WORD_BITS,
  parameter int MAX_ITEMS = mxt_pkg::DEF_MAX_ITEMS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic [mxt_pkg::FIELD_BITS-1:0] in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mxt_pkg::FIELD_BITS-1:0] out_best_xor,
  output logic [1:0]                     out_status
);

  localparam int NW     = $clog2(NODES);
  localparam int NFW    = $clog2(NODES + 1);
  localparam int CW     = $clog2(MAX_ITEMS + 1);
  localparam int DW     = $clog2(WORD_BITS + 1);
  localparam int SUMW   = NFW + 1;
  localparam int NODE_W = 2 * NW + 2 + CW;

  typedef struct packed {
    logic [NW-1:0] link1;
    logic [NW-1:0] link0;
    logic [1:0]    present;
    logic [CW-1:0] count;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WRITE,
    S_QUERY,
    S_DONE
  } state_t;

  state_t                         state_r, state_nxt;
  logic [1:0]                     op_r, op_nxt;
  logic [1:0]                     status_r, status_nxt;
  logic [DW-1:0]                  depth_r, depth_nxt;
  logic [NW-1:0]                  node_r, node_nxt;
  logic                           fresh_r, fresh_nxt;
  node_t                          cur_r, cur_nxt;
  logic [NW-1:0]                  root_link0_r, root_link0_nxt;
  logic [NW-1:0]                  root_link1_r, root_link1_nxt;
  logic [1:0]                     root_present_r, root_present_nxt;
  logic [CW-1:0]                  root_count_r, root_count_nxt;
  logic [NFW-1:0]                 next_free_r, next_free_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [mxt_pkg::FIELD_BITS-1:0] out_best_r, out_best_nxt;
  logic [1:0]                     out_status_r, out_status_nxt;

  logic                ram_we;
  logic [NW-1:0]       ram_raddr_a;
  logic [NW-1:0]       ram_raddr_b;
  logic [NODE_W-1:0]   ram_rdata_a;
  logic [NODE_W-1:0]   ram_rdata_b;
  node_t               rd_a;
  node_t               rd_b;
  node_t               upd_node;

  mxt_pkg::shift_ctl_t  shift_ctl;
  logic                 cur_bit;
  logic [WORD_BITS-1:0] best;

  node_t         root_node;
  node_t         cur_node;
  logic          at_root;
  logic          at_leaf;
  logic          has_b;
  logic [NW-1:0] child_b;
  logic [NW-1:0] free_idx;
  logic          alloc;
  logic [NW-1:0] wr_child;
  logic          set_empty;
  logic          set_full;
  logic          room_for_path;
  logic          path_overflow;
  logic          opp_bit;
  node_t         opp_node;
  logic          take_opp;
  node_t         chosen;

  mxt_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (node_r),
    .wdata   (upd_node),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  mxt_shifter #(
    .WORD_BITS (WORD_BITS)
  ) u_shifter (
    .clk     (clk),
    .ctl     (shift_ctl),
    .word_in (WORD_BITS'(in_word)),
    .cur_bit (cur_bit),
    .best    (best)
  );

  assign rd_a = ram_rdata_a;
  assign rd_b = ram_rdata_b;

  assign root_node = '{link1: root_link1_r, link0: root_link0_r,
                       present: root_present_r, count: root_count_r};

  assign at_root  = (depth_r == '0);
  assign at_leaf  = (depth_r == DW'(WORD_BITS));
  assign free_idx = next_free_r[NW-1:0];

  // Node under the walk in the check and write passes: the root lives in
  // registers, and a node allocated one level up has not been written yet.
  always_comb begin
    if (at_root) begin
      cur_node = root_node;
    end else if (fresh_r) begin
      cur_node = '0;
    end else begin
      cur_node = rd_a;
    end
  end

  assign has_b   = cur_node.present[cur_bit];
  assign child_b = cur_bit ? cur_node.link1 : cur_node.link0;
  assign alloc   = (op_r == mxt_pkg::OP_INSERT) && !at_leaf && !has_b;
  assign wr_child = alloc ? free_idx : child_b;

  always_comb begin
    upd_node = cur_node;
    if (op_r == mxt_pkg::OP_INSERT) begin
      upd_node.count = cur_node.count + CW'(1);
    end else begin
      upd_node.count = cur_node.count - CW'(1);
    end
    if (alloc) begin
      if (cur_bit) begin
        upd_node.link1 = free_idx;
      end else begin
        upd_node.link0 = free_idx;
      end
      upd_node.present[cur_bit] = 1'b1;
    end
  end

  assign set_empty     = (root_count_r == '0);
  assign set_full      = (root_count_r >= CW'(MAX_ITEMS));
  assign room_for_path = ({1'b0, next_free_r} + SUMW'(WORD_BITS)) <= SUMW'(NODES);
  // Nodes still missing below this level are one per remaining bit.
  assign path_overflow = ({1'b0, next_free_r} + SUMW'(WORD_BITS) - SUMW'(depth_r))
                         > SUMW'(NODES);

  // Query step: both children of the current node are read in parallel, and the
  // one opposite to the word's bit wins when it exists and holds words.
  assign opp_bit  = ~cur_bit;
  assign opp_node = opp_bit ? rd_b : rd_a;
  assign take_opp = cur_r.present[opp_bit] && (opp_node.count != '0);
  assign chosen   = (take_opp ? opp_bit : cur_bit) ? rd_b : rd_a;

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    status_nxt       = status_r;
    depth_nxt        = depth_r;
    node_nxt         = node_r;
    fresh_nxt        = fresh_r;
    cur_nxt          = cur_r;
    root_link0_nxt   = root_link0_r;
    root_link1_nxt   = root_link1_r;
    root_present_nxt = root_present_r;
    root_count_nxt   = root_count_r;
    next_free_nxt    = next_free_r;
    out_valid_nxt    = out_valid_r;
    out_best_nxt     = out_best_r;
    out_status_nxt   = out_status_r;
    ram_we           = 1'b0;
    ram_raddr_a      = root_link0_r;
    ram_raddr_b      = root_link1_r;
    shift_ctl        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          shift_ctl.load = 1'b1;
          op_nxt         = in_op;
          status_nxt     = mxt_pkg::ST_OK;
          depth_nxt      = '0;
          fresh_nxt      = 1'b0;
          cur_nxt        = root_node;
          case (in_op)
            mxt_pkg::OP_INSERT: begin
              if (set_full) begin
                status_nxt = mxt_pkg::ST_FULL;
                state_nxt  = S_DONE;
              end else if (room_for_path) begin
                state_nxt = S_WRITE;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            mxt_pkg::OP_DELETE: begin
              if (set_empty) begin
                status_nxt = mxt_pkg::ST_ABSENT;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_CHECK;
              end
            end
            mxt_pkg::OP_QUERY: begin
              if (set_empty) begin
                status_nxt = mxt_pkg::ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_QUERY;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_CHECK: begin
        shift_ctl.step = 1'b1;
        depth_nxt      = depth_r + DW'(1);
        node_nxt       = child_b;
        ram_raddr_a    = child_b;
        if (op_r == mxt_pkg::OP_INSERT) begin
          if (at_leaf || has_b) begin
            if (at_leaf) begin
              shift_ctl.rewind = 1'b1;
              depth_nxt        = '0;
              fresh_nxt        = 1'b0;
              state_nxt        = S_WRITE;
            end
          end else if (path_overflow) begin
            status_nxt = mxt_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            shift_ctl.rewind = 1'b1;
            depth_nxt        = '0;
            fresh_nxt        = 1'b0;
            state_nxt        = S_WRITE;
          end
        end else begin
          if ((!at_root && (cur_node.count == '0)) || (!at_leaf && !has_b)) begin
            status_nxt = mxt_pkg::ST_ABSENT;
            state_nxt  = S_DONE;
          end else if (at_leaf) begin
            shift_ctl.rewind = 1'b1;
            depth_nxt        = '0;
            fresh_nxt        = 1'b0;
            state_nxt        = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        shift_ctl.step = 1'b1;
        depth_nxt      = depth_r + DW'(1);
        node_nxt       = wr_child;
        ram_raddr_a    = wr_child;
        fresh_nxt      = alloc;
        if (at_root) begin
          root_link0_nxt   = upd_node.link0;
          root_link1_nxt   = upd_node.link1;
          root_present_nxt = upd_node.present;
          root_count_nxt   = upd_node.count;
        end else begin
          ram_we = 1'b1;
        end
        if (alloc) begin
          next_free_nxt = next_free_r + NFW'(1);
        end
        if (at_leaf) begin
          state_nxt = S_DONE;
        end
      end

      S_QUERY: begin
        shift_ctl.step     = 1'b1;
        shift_ctl.best_bit = take_opp;
        depth_nxt          = depth_r + DW'(1);
        cur_nxt            = chosen;
        ram_raddr_a        = chosen.link0;
        ram_raddr_b        = chosen.link1;
        if (depth_r == DW'(WORD_BITS - 1)) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_best_nxt   = mxt_pkg::FIELD_BITS'(best);
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      root_present_r <= '0;
      root_count_r   <= '0;
      next_free_r    <= NFW'(1);
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      root_present_r <= root_present_nxt;
      root_count_r   <= root_count_nxt;
      next_free_r    <= next_free_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    depth_r      <= depth_nxt;
    node_r       <= node_nxt;
    fresh_r      <= fresh_nxt;
    cur_r        <= cur_nxt;
    root_link0_r <= root_link0_nxt;
    root_link1_r <= root_link1_nxt;
    out_best_r   <= out_best_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_best_xor = out_best_r;
  assign out_status   = out_status_r;

endmodule

// ----- rtl/mxt_checker.sv -----
// Port-level checks of the maximum-xor trie unit and their binding.
module mxt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mxt_pkg::FIELD_BITS-1:0] out_best_xor,
  input logic [1:0]                     out_status
);

  // One transaction at a time: after an acceptance the input side is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a transaction");

  // Every error result carries a zero xor value.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != mxt_pkg::ST_OK) |-> (out_best_xor == '0))
    else $error("error result with nonzero xor value");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_xor) && $stable(out_status))
    else $error("stalled result changed or dropped");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind multiset_max_xor_trie_unit mxt_checker u_mxt_checker (.*);

// ----- bench/tb_multiset_max_xor_trie_unit.sv -----
// Self-checking testbench of the multiset maximum-xor trie unit.
`timescale 1ns / 100ps

module tb_multiset_max_xor_trie_unit;

  localparam int NODES      = mxt_pkg::DEF_NODES;
  localparam int MAX_ITEMS  = mxt_pkg::DEF_MAX_ITEMS;
  localparam int RUN_LIMIT  = 1500000;
  localparam int MIXED_OPS  = 400;
  localparam int GROW_OPS   = 250;
  localparam int HOLD_OFF   = 80;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] best_xor;
    logic [1:0]  status;
  } answer_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] word;
    logic        typed;
    logic [31:0] best_xor;
    logic [1:0]  status;
  } step_row_t;

  // Rows with typed set carry an answer read straight off the trie contents.
  localparam step_row_t DIRECTED_ROWS [25] = '{
    {mxt_pkg::OP_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_EMPTY},
    {mxt_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxt_pkg::ST_EMPTY},
    {mxt_pkg::OP_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_ABSENT},
    {OP_UNUSED,          32'h1234_5678, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, mxt_pkg::ST_OK},
    {mxt_pkg::OP_QUERY,  32'h0000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_QUERY,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, mxt_pkg::ST_OK},
    {mxt_pkg::OP_QUERY,  32'h0000_FFFF, 1'b1, 32'hFFFF_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_DELETE, 32'h8000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_ABSENT},
    {mxt_pkg::OP_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, mxt_pkg::ST_OK},
    {mxt_pkg::OP_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_DELETE, 32'h0000_0000, 1'b1, 32'h0000_0000, mxt_pkg::ST_ABSENT},
    {mxt_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_INSERT, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_INSERT, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_QUERY,  32'h1234_5678, 1'b0, 32'h0000_0000, mxt_pkg::ST_OK},
    {OP_UNUSED,          32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_DELETE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_DELETE, 32'hA5A5_A5A5, 1'b0, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_DELETE, 32'h5A5A_5A5A, 1'b0, 32'h0000_0000, mxt_pkg::ST_OK},
    {mxt_pkg::OP_QUERY,  32'h0000_0001, 1'b1, 32'h0000_0000, mxt_pkg::ST_EMPTY}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = mxt_pkg::OP_INSERT;
  logic [31:0] in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_best_xor;
  logic [1:0]  out_status;

  // Trie mirror used to predict every answer not given by a typed row.
  logic [14:0] link0 [NODES];
  logic [14:0] link1 [NODES];
  logic [1:0]  link_mask [NODES];
  logic [10:0] pass_count [NODES];
  int unsigned alloc_next;
  int unsigned held_total;
  int unsigned node_full_hits;

  answer_t     owed_results [$];
  logic [31:0] held_words [$];
  logic [31:0] word_pool [8];
  answer_t     want;
  int unsigned err_count = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  bit          sender_quiet = 1'b0;
  bit          receiver_quiet = 1'b0;

  multiset_max_xor_trie_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_best_xor (out_best_xor),
    .out_status   (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
  end

  function automatic logic [14:0] kid(input logic [14:0] node, input logic b);
    kid = b ? link1[node] : link0[node];
  endfunction

  function automatic logic [1:0] trie_insert(input logic [31:0] w);
    logic [14:0] node;
    logic [14:0] fresh;
    int unsigned missing;
    bit walking;
    node = '0;
    missing = 0;
    walking = 1'b1;
    for (int lvl = 31; lvl >= 0 && walking; lvl--) begin
      if (!link_mask[node][w[lvl]]) begin
        missing = lvl + 1;
        walking = 1'b0;
      end else begin
        node = kid(node, w[lvl]);
      end
    end
    // Either the word count or the node space may be exhausted.
    if (held_total >= MAX_ITEMS || alloc_next + missing > NODES) begin
      if (held_total < MAX_ITEMS) node_full_hits++;
      return mxt_pkg::ST_FULL;
    end
    held_total++;
    node = '0;
    for (int lvl = 31; lvl >= 0; lvl--) begin
      if (!link_mask[node][w[lvl]]) begin
        fresh = 15'(alloc_next);
        if (w[lvl]) link1[node] = fresh;
        else link0[node] = fresh;
        link_mask[node][w[lvl]] = 1'b1;
        link_mask[fresh] = 2'b00;
        pass_count[fresh] = '0;
        alloc_next++;
      end
      node = kid(node, w[lvl]);
      pass_count[node] = pass_count[node] + 11'd1;
    end
    return mxt_pkg::ST_OK;
  endfunction

  function automatic logic [1:0] trie_delete(input logic [31:0] w);
    logic [14:0] node;
    bit found;
    if (held_total == 0) return mxt_pkg::ST_ABSENT;
    node = '0;
    found = 1'b1;
    // A node left behind with a zero count means the word is gone.
    for (int lvl = 31; lvl >= 0 && found; lvl--) begin
      if (!link_mask[node][w[lvl]]) begin
        found = 1'b0;
      end else begin
        node = kid(node, w[lvl]);
        if (pass_count[node] == 0) found = 1'b0;
      end
    end
    if (!found) return mxt_pkg::ST_ABSENT;
    held_total--;
    node = '0;
    for (int lvl = 31; lvl >= 0; lvl--) begin
      node = kid(node, w[lvl]);
      pass_count[node] = pass_count[node] - 11'd1;
    end
    return mxt_pkg::ST_OK;
  endfunction

  function automatic logic [31:0] trie_best_xor(input logic [31:0] w);
    logic [14:0] node;
    logic [31:0] best;
    logic o;
    node = '0;
    best = '0;
    for (int lvl = 31; lvl >= 0; lvl--) begin
      o = ~w[lvl];
      if (link_mask[node][o] && pass_count[kid(node, o)] != 0) begin
        best[lvl] = 1'b1;
        node = kid(node, o);
      end else begin
        node = kid(node, w[lvl]);
      end
    end
    return best;
  endfunction

  function automatic answer_t max_xor_trie_apply(input logic [1:0] op, input logic [31:0] w);
    answer_t a;
    a = '0;
    a.status = mxt_pkg::ST_OK;
    case (op)
      mxt_pkg::OP_INSERT: a.status = trie_insert(w);
      mxt_pkg::OP_DELETE: a.status = trie_delete(w);
      mxt_pkg::OP_QUERY: begin
        if (held_total == 0) a.status = mxt_pkg::ST_EMPTY;
        else a.best_xor = trie_best_xor(w);
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if ($urandom_range(0, 59) == 0) sender_quiet = !sender_quiet;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (held_words.size() != 0 && r < 30)
      return held_words[$urandom_range(0, held_words.size() - 1)];
    // Flipping one bit of a stored word diverges from an existing path at the flipped bit.
    if (held_words.size() != 0 && r < 50)
      return held_words[$urandom_range(0, held_words.size() - 1)] ^
             (32'h1 << $urandom_range(0, 31));
    if (r < 70) return word_pool[3'($urandom_range(0, 7))];
    return $urandom();
  endfunction

  function automatic logic [31:0] any_held();
    return held_words[$urandom_range(0, held_words.size() - 1)];
  endfunction

  // Offers one transaction, waits for it to be taken and books its answer.
  task automatic send(input logic [1:0] op, input logic [31:0] w,
                      input bit typed = 1'b0, input answer_t typed_ans = '0);
    answer_t a;
    int unsigned gap;
    int idx;
    gap = sender_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op <= op;
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    a = max_xor_trie_apply(op, w);
    owed_results.push_back(typed ? typed_ans : a);
    if (a.status == mxt_pkg::ST_OK && op == mxt_pkg::OP_INSERT) held_words.push_back(w);
    if (a.status == mxt_pkg::ST_OK && op == mxt_pkg::OP_DELETE) begin
      idx = -1;
      foreach (held_words[i]) if (idx < 0 && held_words[i] == w) idx = i;
      if (idx >= 0) held_words.delete(idx);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_results.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (owed_results.size() == 0) begin
        $error("result with no transaction outstanding: best_xor %h status %0d",
               out_best_xor, out_status);
        err_count++;
      end else begin
        want = owed_results.pop_front();
        if (out_best_xor !== want.best_xor) begin
          $error("best_xor: expected %h, got %h", want.best_xor, out_best_xor);
          err_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_count++;
        end
        status_seen[want.status]++;
        checked++;
      end
    end
  end

  initial begin
    int unsigned stall_left;
    int unsigned r;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        r = $urandom_range(0, 99);
        if (!receiver_quiet && r >= 70)
          stall_left = (r < 94) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        if ($urandom_range(0, 199) == 0) receiver_quiet = !receiver_quiet;
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned r;
    foreach (link_mask[i]) begin
      link_mask[i] = 2'b00;
      link0[i] = '0;
      link1[i] = '0;
      pass_count[i] = '0;
    end
    alloc_next = 1;
    held_total = 0;
    node_full_hits = 0;
    foreach (word_pool[i]) word_pool[i] = $urandom();
    word_pool[0] = 32'h0000_0000;
    word_pool[1] = 32'hFFFF_FFFF;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[i])
      send(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed,
           {DIRECTED_ROWS[i].best_xor, DIRECTED_ROWS[i].status});

    // Small sets with duplicates, near misses and periodic emptying.
    for (int k = 0; k < MIXED_OPS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send(mxt_pkg::OP_INSERT, pick_word());
      else if (r < 65)
        send(mxt_pkg::OP_DELETE, (held_words.size() != 0 && $urandom_range(0, 99) < 70) ?
                                 any_held() : pick_word());
      else if (r < 95) send(mxt_pkg::OP_QUERY, pick_word());
      else send(OP_UNUSED, $urandom());
      if (k % 100 == 99) begin
        wait_drained();
        while (held_words.size() != 0) send(mxt_pkg::OP_DELETE, any_held());
        send(mxt_pkg::OP_QUERY, $urandom());
      end
    end

    // Grow a larger set of scattered words with queries mixed in.
    wait_drained();
    repeat (GROW_OPS) begin
      if ($urandom_range(0, 9) == 0) send(mxt_pkg::OP_QUERY, pick_word());
      else send(mxt_pkg::OP_INSERT, $urandom());
    end
    // Duplicates of stored words, then shrink the set again.
    repeat (6) send(mxt_pkg::OP_INSERT, any_held());
    repeat (40) begin
      send(mxt_pkg::OP_DELETE, any_held());
      if ($urandom_range(0, 1) == 0) send(mxt_pkg::OP_QUERY, pick_word());
    end
    send(OP_UNUSED, 32'hFFFF_FFFF);

    wait_drained();
    repeat (HOLD_OFF) @(posedge clk);
    $display("Checked %0d transactions in %0d cycles: %0d ok, %0d empty set, %0d absent word.",
             checked, cycles, status_seen[mxt_pkg::ST_OK], status_seen[mxt_pkg::ST_EMPTY],
             status_seen[mxt_pkg::ST_ABSENT]);
    $display("Table full %0d times (%0d for lack of nodes), %0d of %0d nodes allocated.",
             status_seen[mxt_pkg::ST_FULL], node_full_hits, alloc_next, NODES);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
